FILE: hdl/bwc_pkg.sv
// ----------------------------------------------------------------------------
// Block write-combine controller package
// Command, request and register codes shared by the controller, its checker and the testbench.
// ----------------------------------------------------------------------------
package bwc_pkg;

  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_WRITE      = 3'd1;
  localparam logic [2:0] CMD_INVALIDATE = 3'd2;
  localparam logic [2:0] CMD_REMOVED    = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;

  localparam logic [2:0] REQ_FLUSH  = 3'd0;
  localparam logic [2:0] REQ_RELOAD = 3'd1;
  localparam logic [2:0] REQ_COPY   = 3'd2;
  localparam logic [2:0] REQ_STORE  = 3'd3;
  localparam logic [2:0] REQ_DWRITE = 3'd4;
  localparam logic [2:0] REQ_DREAD  = 3'd5;
  localparam logic [2:0] REQ_SHIFT  = 3'd6;
  localparam logic [2:0] REQ_DONE   = 3'd7;

  localparam logic [1:0] REG_MEDIA_BLOCKS = 2'd0;
  localparam logic [1:0] REG_WRITE_CAP    = 2'd1;
  localparam logic [1:0] REG_READ_CAP     = 2'd2;
  localparam logic [1:0] REG_FLUSH_DELAY  = 2'd3;

endpackage

FILE: hdl/block_write_combine_readahead_ctrl.sv
// ----------------------------------------------------------------------------
// Block write-combine and read-ahead controller
// Turns block commands into buffer and media transfer requests plus a done.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake      | Payload
// cmd      | in        | valid / stall  | command, start_block, block_count
// request  | out       | out_valid / out_stall | request_kind .. last
// cfg      | in        | cfg_write      | cfg_index, cfg_data
//
// A command is taken in idle, then passes through decode and the later
// sequencer steps, so stall stays high from the accepting edge until the
// done is issued. A write or a direct read goes decode, transfer, done;
// invalidate, tick and media removal go decode, done; a zero count ends at
// decode; a read through the read-ahead window runs up to sixteen one-block
// reloads. A flush goes out from decode. Reset is synchronous and empties
// both buffers. A stalled output holds the request and the sequencer waits.
module block_write_combine_readahead_ctrl
  import bwc_pkg::*;
#(
  parameter int BLOCK_NUMBER_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic [2:0]                   command,
  input  logic [BLOCK_NUMBER_BITS-1:0] start_block,
  input  logic [4:0]                   block_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   request_kind,
  output logic [BLOCK_NUMBER_BITS-1:0] media_block,
  output logic [4:0]                   transfer_blocks,
  output logic [3:0]                   buffer_offset,
  output logic                         status,
  output logic                         last,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  localparam int B = BLOCK_NUMBER_BITS;
  localparam logic [4:0] MAXN = 5'd16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RCPY = 3'd2;
  localparam logic [2:0] S_RLD  = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [31:0] media_blocks;
  logic [4:0] write_capacity, readahead_capacity;
  logic [15:0] flush_delay_ticks;
  logic [B-1:0] wbuf_start, wbuf_expected, rbuf_start;
  logic [4:0] wbuf_count, rbuf_count;
  logic [15:0] flush_timer;
  logic timer_armed;

  logic [2:0] cmd;
  logic [B-1:0] s, cur;
  logic [4:0] n, rem, got;
  logic st;

  // Output register
  logic [2:0] o_kind;
  logic [B-1:0] o_blk;
  logic [4:0] o_cnt;
  logic [3:0] o_off;
  logic o_st, o_last;

  assign request_kind = o_kind;
  assign media_block = o_blk;
  assign transfer_blocks = o_cnt;
  assign buffer_offset = o_off;
  assign status = o_st;
  assign last = o_last;

  assign stall = (state != S_IDLE);
  wire out_free = !out_valid || !out_stall;

  wire [4:0] ncap = (block_count > MAXN) ? MAXN : block_count;
  wire [4:0] wcap = (write_capacity > MAXN) ? MAXN : write_capacity;
  wire [4:0] rcap = (readahead_capacity > MAXN) ? MAXN : readahead_capacity;
  wire [B-1:0] media = B'(media_blocks);

  // Extended arithmetic, one bit wider to avoid wrap.
  wire [B:0] s_x = {1'b0, s};
  wire [B:0] iend = s_x + {{(B-4){1'b0}}, n};
  wire [B:0] wend = {1'b0, wbuf_start} + {{(B-4){1'b0}}, wbuf_count};
  wire [B:0] rend = {1'b0, rbuf_start} + {{(B-4){1'b0}}, rbuf_count};
  wire w_ovl = (wbuf_count != 5'd0) && ({1'b0, wbuf_start} < iend) && (s_x < wend);
  wire r_ovl = (rbuf_count != 5'd0) && ({1'b0, rbuf_start} < iend) && (s_x < rend);
  wire [5:0] wsum = {1'b0, wbuf_count} + {1'b0, n};
  wire w_flush = (wbuf_count != 5'd0) &&
                 (n > wcap || s != wbuf_expected || wsum > {1'b0, wcap});

  // Invalidation cases: the cut touches a buffer, or covers all of it.
  wire w_hit = (wbuf_count != 5'd0) && !(wend <= s_x || {1'b0, wbuf_start} >= iend);
  wire w_cover = ({1'b0, wbuf_start} >= s_x) && (wend <= iend);
  wire r_hit = (rbuf_count != 5'd0) && !(rend <= s_x || {1'b0, rbuf_start} >= iend);

  // Store position: a fresh buffer starts at the write itself.
  wire [B-1:0] wstore_base = (wbuf_count == 5'd0) ? s : wbuf_start;

  // Read step unit
  wire [B:0] cur_x = {1'b0, cur};
  wire in_r = (rbuf_count != 5'd0) && (cur >= rbuf_start) && (cur_x < rend);
  wire [B:0] rd_full = rend - cur_x;
  wire [4:0] rd = (rd_full > {{(B-4){1'b0}}, rem}) ? rem : rd_full[4:0];
  wire [B:0] ld_end_raw = cur_x + {{(B-4){1'b0}}, rcap};
  wire [B:0] ld_end = (ld_end_raw > {1'b0, media}) ? {1'b0, media} : ld_end_raw;
  wire [4:0] ld_cnt = 5'(ld_end - cur_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      media_blocks <= 32'd1024;
      write_capacity <= 5'd16;
      readahead_capacity <= 5'd16;
      flush_delay_ticks <= 16'd35;
      wbuf_start <= '1;
      wbuf_expected <= '1;
      wbuf_count <= '0;
      rbuf_start <= '1;
      rbuf_count <= '0;
      flush_timer <= '0;
      timer_armed <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MEDIA_BLOCKS: media_blocks <= cfg_data;
          REG_WRITE_CAP:    write_capacity <= cfg_data[4:0];
          REG_READ_CAP:     readahead_capacity <= cfg_data[4:0];
          REG_FLUSH_DELAY:  flush_delay_ticks <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (out_free) out_valid <= 1'b0;
          if (valid) begin
            cmd <= command;
            s <= start_block;
            cur <= start_block;
            n <= ncap;
            rem <= ncap;
            got <= '0;
            st <= 1'b0;
            state <= S_DEC;
          end
        end
        S_DEC: if (out_free) begin
          if (cmd <= CMD_INVALIDATE && n == 5'd0) begin
            o_kind <= REQ_DONE; o_blk <= s; o_cnt <= '0; o_off <= '0;
            o_st <= 1'b0; o_last <= 1'b1; out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (cmd == CMD_READ) begin
            if (w_ovl) begin
              o_kind <= REQ_FLUSH; o_blk <= wbuf_start; o_cnt <= wbuf_count;
              o_off <= '0; o_st <= 1'b0; o_last <= 1'b0; out_valid <= 1'b1;
              wbuf_count <= '0; wbuf_start <= '1; wbuf_expected <= '1;
              timer_armed <= 1'b0; flush_timer <= '0;
            end else out_valid <= 1'b0;
            if (rcap == 5'd0) state <= S_W2;
            else state <= S_RCPY;
          end else if (cmd == CMD_WRITE) begin
            if (r_ovl) begin rbuf_count <= '0; rbuf_start <= '1; end
            if (w_flush) begin
              o_kind <= REQ_FLUSH; o_blk <= wbuf_start; o_cnt <= wbuf_count;
              o_off <= '0; o_st <= 1'b0; o_last <= 1'b0; out_valid <= 1'b1;
              wbuf_count <= '0; wbuf_start <= '1; wbuf_expected <= '1;
              timer_armed <= 1'b0; flush_timer <= '0;
            end else out_valid <= 1'b0;
            state <= S_W2;
          end else if (cmd == CMD_INVALIDATE) begin
            if (w_hit && w_cover) begin
              wbuf_count <= '0; wbuf_start <= '1; wbuf_expected <= '1;
              timer_armed <= 1'b0; flush_timer <= '0;
              out_valid <= 1'b0;
            end else if (w_hit && wbuf_start < s) begin
              // A hole in the middle sends the tail to the media.
              if (wend > iend) begin
                o_kind <= REQ_FLUSH; o_blk <= B'(iend); o_cnt <= 5'(wend - iend);
                o_off <= 4'(iend - {1'b0, wbuf_start}); o_st <= 1'b0; o_last <= 1'b0;
                out_valid <= 1'b1;
              end else out_valid <= 1'b0;
              wbuf_count <= 5'(s - wbuf_start);
              wbuf_expected <= s;
            end else if (w_hit) begin
              o_kind <= REQ_SHIFT; o_blk <= B'(iend); o_cnt <= 5'(wend - iend);
              o_off <= 4'(iend - {1'b0, wbuf_start}); o_st <= 1'b0; o_last <= 1'b0;
              out_valid <= 1'b1;
              wbuf_start <= B'(iend);
              wbuf_count <= 5'(wend - iend);
            end else out_valid <= 1'b0;
            if (r_hit) begin
              if (rbuf_start < s) rbuf_count <= 5'(s - rbuf_start);
              else begin rbuf_count <= '0; rbuf_start <= '1; end
            end
            got <= n;
            state <= S_DONE;
          end else if (cmd == CMD_REMOVED) begin
            wbuf_count <= '0; wbuf_start <= '1; wbuf_expected <= '1;
            timer_armed <= 1'b0; flush_timer <= '0;
            rbuf_count <= '0; rbuf_start <= '1;
            out_valid <= 1'b0;
            s <= '0; got <= '0;
            state <= S_DONE;
          end else if (cmd == CMD_TICK) begin
            if (timer_armed && flush_timer <= 16'd1) begin
              if (wbuf_count != 5'd0) begin
                o_kind <= REQ_FLUSH; o_blk <= wbuf_start; o_cnt <= wbuf_count;
                o_off <= '0; o_st <= 1'b0; o_last <= 1'b0; out_valid <= 1'b1;
              end else out_valid <= 1'b0;
              wbuf_count <= '0; wbuf_start <= '1; wbuf_expected <= '1;
              timer_armed <= 1'b0; flush_timer <= '0;
            end else begin
              if (timer_armed) flush_timer <= flush_timer - 16'd1;
              out_valid <= 1'b0;
            end
            s <= '0; got <= '0;
            state <= S_DONE;
          end else begin
            out_valid <= 1'b0;
            s <= '0; got <= '0;
            state <= S_DONE;
          end
        end
        S_RCPY: if (out_free) begin
          if (in_r) begin
            o_kind <= REQ_COPY; o_blk <= cur; o_cnt <= rd;
            o_off <= 4'(cur - rbuf_start); o_st <= 1'b0; o_last <= 1'b0;
            out_valid <= 1'b1;
            cur <= cur + B'(rd);
            rem <= rem - rd;
            got <= got + rd;
            state <= (rem == rd) ? S_DONE : S_RLD;
          end else begin
            out_valid <= 1'b0;
            state <= S_RLD;
          end
        end
        S_RLD: if (out_free) begin
          if (cur >= media) begin
            st <= 1'b1;
            out_valid <= 1'b0;
            state <= S_DONE;
          end else begin
            o_kind <= REQ_RELOAD; o_blk <= cur; o_cnt <= ld_cnt;
            o_off <= '0; o_st <= 1'b0; o_last <= 1'b0; out_valid <= 1'b1;
            rbuf_start <= cur;
            rbuf_count <= ld_cnt;
            state <= S_RCPY;
          end
        end
        S_W2: if (out_free) begin
          o_st <= 1'b0; o_last <= 1'b0; o_blk <= s; o_cnt <= n;
          out_valid <= 1'b1;
          got <= n;
          if (cmd == CMD_READ) begin
            o_kind <= REQ_DREAD; o_off <= '0;
          end else if (n > wcap) begin
            o_kind <= REQ_DWRITE; o_off <= '0;
          end else begin
            o_kind <= REQ_STORE;
            o_off <= 4'(wbuf_count);
            wbuf_start <= wstore_base;
            wbuf_expected <= wstore_base + B'(wbuf_count + n);
            wbuf_count <= wbuf_count + n;
            flush_timer <= flush_delay_ticks;
            timer_armed <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: if (out_free) begin
          o_kind <= REQ_DONE; o_blk <= s; o_cnt <= got; o_off <= '0;
          o_st <= st; o_last <= 1'b1; out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/bwc_checker.sv
// ----------------------------------------------------------------------------
// Block write-combine controller checker
// Port-level properties of the command and request channels.
// ----------------------------------------------------------------------------
module bwc_checker
  import bwc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] request_kind,
  input logic       last,
  input logic       status
);
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> request_kind == REQ_DONE) else $error("last on non-done");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_kind == REQ_DONE |-> last) else $error("done without last");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> request_kind == REQ_DONE) else $error("status on request");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(request_kind)) else $error("out dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> stall) else $error("accepted without going busy");
endmodule

bind block_write_combine_readahead_ctrl bwc_checker u_bwc_checker (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall), .out_valid(out_valid),
  .out_stall(out_stall), .request_kind(request_kind), .last(last), .status(status)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Write-combine and read-ahead controller testbench
// Drives block commands through the valid/stall port under random idling,
// predicts every transfer request and done, and checks each one in order.
// Several register settings are visited, extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import bwc_pkg::*;

  typedef longint unsigned u64;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] blk;
    logic [4:0]  cnt;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] blk;
    logic [4:0]  cnt;
    logic [3:0]  off;
    logic        st;
    logic        lst;
  } req_item_t;

  localparam u64 ALL_ONES = 64'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [2:0]  command = '0;
  logic [31:0] start_block = '0;
  logic [4:0]  block_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  request_kind;
  logic [31:0] media_block;
  logic [4:0]  transfer_blocks;
  logic [3:0]  buffer_offset;
  logic        status;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  block_write_combine_readahead_ctrl dut (.*);

  cmd_item_t pending_cmds[$];
  req_item_t expected_reqs[$];
  int        sent_cnt = 0;
  int        taken_cnt = 0;
  int        errors = 0;
  int        cmd_gap = 0;
  int        req_gap = 0;
  bit        quiet = 1'b0;

  // Predicted controller state and registers.
  u64 media_size, wr_cap, ra_cap, delay_ticks;
  u64 wr_start, wr_count, wr_next, rd_start, rd_count, timer_val;
  bit timer_on;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic push_req(logic [2:0] k, u64 b, u64 c, u64 o, bit st, bit lst);
    req_item_t r;
    r.kind = k;
    r.blk  = b[31:0];
    r.cnt  = c[4:0];
    r.off  = o[3:0];
    r.st   = st;
    r.lst  = lst;
    expected_reqs.push_back(r);
  endtask

  function automatic bit ranges_meet(u64 a, u64 an, u64 b, u64 bn);
    return (a < b + bn) && (b < a + an);
  endfunction

  task automatic wr_empty();
    wr_count  = 0;
    wr_start  = ALL_ONES;
    wr_next   = ALL_ONES;
    timer_on  = 1'b0;
    timer_val = 0;
  endtask

  task automatic rd_empty();
    rd_count = 0;
    rd_start = ALL_ONES;
  endtask

  task automatic wr_flush();
    if (wr_count != 0) begin
      push_req(REQ_FLUSH, wr_start, wr_count, 0, 1'b0, 1'b0);
      wr_empty();
    end
  endtask

  task automatic predict_read(u64 s, u64 n);
    u64 rcap, cur, rem, got, take, e;
    bit st;
    rcap = (ra_cap > 16) ? 16 : ra_cap;
    cur = s;
    rem = n;
    got = 0;
    st = 1'b0;
    if (wr_count != 0 && ranges_meet(wr_start, wr_count, s, n)) wr_flush();
    if (rcap == 0) begin
      push_req(REQ_DREAD, s, n, 0, 1'b0, 1'b0);
      push_req(REQ_DONE, s, n, 0, 1'b0, 1'b1);
      return;
    end
    while (rem != 0) begin
      if (rd_count != 0 && cur >= rd_start && cur < rd_start + rd_count) begin
        take = rd_start + rd_count - cur;
        if (take > rem) take = rem;
        push_req(REQ_COPY, cur, take, cur - rd_start, 1'b0, 1'b0);
        cur += take;
        rem -= take;
        got += take;
      end
      if (rem != 0) begin
        if (cur >= media_size) begin
          st = 1'b1;
          break;
        end
        e = cur + rcap;
        if (e > media_size) e = media_size;
        push_req(REQ_RELOAD, cur, e - cur, 0, 1'b0, 1'b0);
        rd_start = cur;
        rd_count = e - cur;
      end
    end
    push_req(REQ_DONE, s, got, 0, st, 1'b1);
  endtask

  task automatic predict_write(u64 s, u64 n);
    u64 wcap;
    wcap = (wr_cap > 16) ? 16 : wr_cap;
    if (rd_count != 0 && ranges_meet(rd_start, rd_count, s, n)) rd_empty();
    if (n > wcap) begin
      wr_flush();
      push_req(REQ_DWRITE, s, n, 0, 1'b0, 1'b0);
    end else begin
      if ((wr_count != 0 && s != wr_next) || wr_count + n > wcap) wr_flush();
      if (wr_count == 0) wr_start = s;
      push_req(REQ_STORE, s, n, wr_count, 1'b0, 1'b0);
      wr_count += n;
      wr_next = (wr_start + wr_count) & ALL_ONES;
      timer_val = delay_ticks;
      timer_on = 1'b1;
    end
    push_req(REQ_DONE, s, n, 0, 1'b0, 1'b1);
  endtask

  task automatic predict_invalidate(u64 s, u64 n);
    u64 iend, ws, wend, rs, rend;
    iend = s + n;
    if (wr_count != 0) begin
      ws = wr_start;
      wend = wr_start + wr_count;
      if (wend <= s || ws >= iend) begin
      end else if (ws >= s && wend <= iend) begin
        wr_empty();
      end else if (ws < s && wend > iend) begin
        // A hole in the middle: the tail goes out to the media.
        push_req(REQ_FLUSH, iend, wend - iend, iend - ws, 1'b0, 1'b0);
        wr_count = s - ws;
        wr_next = (ws + wr_count) & ALL_ONES;
      end else if (ws < s) begin
        wr_count = s - ws;
        wr_next = (ws + wr_count) & ALL_ONES;
      end else begin
        push_req(REQ_SHIFT, iend, wend - iend, iend - ws, 1'b0, 1'b0);
        wr_start = iend & ALL_ONES;
        wr_count = wend - iend;
      end
    end
    if (rd_count != 0) begin
      rs = rd_start;
      rend = rd_start + rd_count;
      if (rend <= s || rs >= iend) begin
      end else if (rs < s) begin
        rd_count = s - rs;
      end else begin
        rd_empty();
      end
    end
    push_req(REQ_DONE, s, n, 0, 1'b0, 1'b1);
  endtask

  task automatic predict_command(cmd_item_t c);
    u64 s, n;
    s = u64'(c.blk);
    n = (c.cnt > 16) ? 16 : u64'(c.cnt);
    if (c.cmd <= CMD_INVALIDATE && n == 0) begin
      push_req(REQ_DONE, s, 0, 0, 1'b0, 1'b1);
      return;
    end
    case (c.cmd)
      CMD_READ:       predict_read(s, n);
      CMD_WRITE:      predict_write(s, n);
      CMD_INVALIDATE: predict_invalidate(s, n);
      CMD_REMOVED: begin
        wr_empty();
        rd_empty();
        push_req(REQ_DONE, 0, 0, 0, 1'b0, 1'b1);
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (timer_val <= 1) begin
            wr_flush();
            timer_on = 1'b0;
            timer_val = 0;
          end else timer_val--;
        end
        push_req(REQ_DONE, 0, 0, 0, 1'b0, 1'b1);
      end
      default: push_req(REQ_DONE, 0, 0, 0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic report_err(string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  // Command driver: a new command is offered once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (taken_cnt == sent_cnt) begin
      if (cmd_gap > 0) begin
        cmd_gap <= cmd_gap - 1;
        valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd_item_t c;
        c = pending_cmds.pop_front();
        command <= c.cmd;
        start_block <= c.blk;
        block_count <= c.cnt;
        valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        if (!quiet && $urandom_range(0, 4) == 0) cmd_gap <= $urandom_range(1, 9);
      end else begin
        valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (req_gap > 0) begin
      out_stall <= 1'b1;
      req_gap <= req_gap - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 9);
    end
  end

  // Monitor: predicts on each accepted command and checks each result.
  always @(posedge clk) begin
    if (rst) begin
      media_size = 1024;
      wr_cap = 16;
      ra_cap = 16;
      delay_ticks = 35;
      wr_empty();
      rd_empty();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MEDIA_BLOCKS: media_size = u64'(cfg_data);
          REG_WRITE_CAP:    wr_cap = u64'(cfg_data[4:0]);
          REG_READ_CAP:     ra_cap = u64'(cfg_data[4:0]);
          REG_FLUSH_DELAY:  delay_ticks = u64'(cfg_data[15:0]);
        endcase
      end
      if (valid && !stall) begin
        cmd_item_t c;
        c.cmd = command;
        c.blk = start_block;
        c.cnt = block_count;
        predict_command(c);
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        req_item_t e;
        if (expected_reqs.size() == 0) begin
          report_err($sformatf("unexpected request kind %0d block %0h",
                               request_kind, media_block));
        end else begin
          e = expected_reqs.pop_front();
          if (request_kind !== e.kind)
            report_err($sformatf("kind %0d, want %0d", request_kind, e.kind));
          if (media_block !== e.blk)
            report_err($sformatf("block %0h, want %0h", media_block, e.blk));
          if (transfer_blocks !== e.cnt)
            report_err($sformatf("count %0d, want %0d", transfer_blocks, e.cnt));
          if (buffer_offset !== e.off)
            report_err($sformatf("offset %0d, want %0d", buffer_offset, e.off));
          if (status !== e.st)
            report_err($sformatf("status %0b, want %0b", status, e.st));
          if (last !== e.lst)
            report_err($sformatf("last %0b, want %0b", last, e.lst));
        end
      end
    end
  end

  task automatic add_cmd(logic [2:0] c, logic [31:0] b, logic [4:0] n);
    cmd_item_t it;
    it.cmd = c;
    it.blk = b;
    it.cnt = n;
    pending_cmds.push_back(it);
  endtask

  task automatic wait_drained();
    while (!(pending_cmds.size() == 0 && taken_cnt == sent_cnt && expected_reqs.size() == 0))
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Mostly sequential write runs with reads, ticks and cuts around them.
  task automatic add_random(int count, logic [31:0] base);
    logic [31:0] seq;
    int r;
    seq = base;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) seq = base + $urandom_range(0, 300);
      if (r < 30) begin
        logic [4:0] n;
        n = 5'($urandom_range(1, 6));
        add_cmd(CMD_WRITE, seq, n);
        seq = seq + n;
      end else if (r < 50) begin
        add_cmd(CMD_READ, seq - $urandom_range(0, 20), 5'($urandom_range(1, 16)));
      end else if (r < 62) begin
        add_cmd(CMD_TICK, $urandom, 5'($urandom_range(0, 31)));
      end else if (r < 72) begin
        add_cmd(CMD_INVALIDATE, seq - $urandom_range(0, 12), 5'($urandom_range(1, 16)));
      end else if (r < 76) begin
        add_cmd(CMD_REMOVED, $urandom, 5'($urandom_range(0, 31)));
      end else if (r < 83) begin
        add_cmd(CMD_WRITE, $urandom, 5'($urandom_range(0, 31)));
      end else if (r < 90) begin
        add_cmd(CMD_READ, $urandom, 5'($urandom_range(0, 31)));
      end else if (r < 94) begin
        add_cmd(3'($urandom_range(5, 7)), $urandom, 5'($urandom_range(0, 31)));
      end else begin
        add_cmd(3'($urandom_range(0, 7)), $urandom, 5'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings.
    add_cmd(CMD_WRITE, 0, 4);
    add_cmd(CMD_WRITE, 4, 4);
    add_cmd(CMD_WRITE, 100, 2);
    add_cmd(CMD_READ, 99, 3);
    add_cmd(CMD_READ, 0, 16);
    add_cmd(CMD_READ, 8, 20);
    add_cmd(CMD_READ, 1020, 16);
    add_cmd(CMD_READ, 2000, 1);
    add_cmd(CMD_WRITE, 5, 31);
    add_cmd(CMD_WRITE, 32'hFFFF_FFFF, 16);
    add_cmd(CMD_READ, 0, 0);
    add_cmd(CMD_WRITE, 7, 0);
    add_cmd(CMD_INVALIDATE, 7, 0);
    add_cmd(3'd5, 32'hFFFF_FFFF, 31);
    add_cmd(3'd7, 1, 1);
    add_cmd(CMD_WRITE, 200, 8);
    add_cmd(CMD_INVALIDATE, 202, 2);
    add_cmd(CMD_WRITE, 202, 6);
    add_cmd(CMD_INVALIDATE, 206, 4);
    add_cmd(CMD_INVALIDATE, 200, 2);
    add_cmd(CMD_READ, 300, 4);
    add_cmd(CMD_INVALIDATE, 305, 2);
    add_cmd(CMD_INVALIDATE, 300, 1);
    add_cmd(CMD_TICK, 0, 0);
    add_cmd(CMD_REMOVED, 0, 0);
    wait_drained();

    write_reg(REG_MEDIA_BLOCKS, 40);
    write_reg(REG_WRITE_CAP, 4);
    write_reg(REG_READ_CAP, 3);
    write_reg(REG_FLUSH_DELAY, 2);
    add_random(55, 0);
    wait_drained();

    write_reg(REG_MEDIA_BLOCKS, 32'hFFFF_FFFF);
    write_reg(REG_WRITE_CAP, 31);
    write_reg(REG_READ_CAP, 0);
    write_reg(REG_FLUSH_DELAY, 0);
    add_random(55, 32'hFFFF_FF00);
    wait_drained();

    write_reg(REG_MEDIA_BLOCKS, 1);
    write_reg(REG_WRITE_CAP, 0);
    write_reg(REG_READ_CAP, 31);
    write_reg(REG_FLUSH_DELAY, 16'hFFFF);
    add_random(30, 0);
    wait_drained();
    write_reg(REG_MEDIA_BLOCKS, 0);
    add_random(15, 0);
    wait_drained();

    write_reg(REG_MEDIA_BLOCKS, 200);
    write_reg(REG_WRITE_CAP, 8);
    write_reg(REG_READ_CAP, 16);
    write_reg(REG_FLUSH_DELAY, 1);
    add_random(40, 0);
    wait_drained();
    quiet = 1'b1;
    add_random(30, 100);
    wait_drained();
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("[block_write_combine_readahead_ctrl] OK");
    end else begin
      $display("[block_write_combine_readahead_ctrl] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[block_write_combine_readahead_ctrl] ERROR");
    $finish;
  end

endmodule
